### design/sst_pkg.sv
// Shared types and constants for the scoped symbol table.
// Used by sst_ctrl, sst_dp and scoped_symbol_table_core.
`default_nettype none

package sst_pkg;

    localparam int NAME_W  = 12;
    localparam int KIND_W  = 4;
    localparam int IDX_W   = 8;
    localparam int LVL_W   = 4;
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_ANON_NAME  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_KIND = 1'd1;

    typedef enum logic [1:0] {
        REQ_DEFINE = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_START  = 2'd2,
        REQ_FINISH = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        OP_DEFINE,
        OP_HIT,
        OP_MISS,
        OP_START,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
        t_op  op;
        logic dup;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic anon;
        logic hit;
        logic more;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

### design/sst_ctrl.sv
// Request sequencer for the scoped symbol table.
// Depends on sst_pkg; drives sst_dp through t_cmd and reads t_stat.
`default_nettype none

module sst_ctrl import sst_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_dup, n_dup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_dup <= n_dup;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_dup      = r_dup;
        o_in_ready = 1'b0;
        o_cmd      = '{load: 1'b0, step: 1'b0, commit: 1'b0, op: r_op, dup: r_dup};
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req)
                    REQ_DEFINE: begin
                        if (i_stat.anon) begin
                            n_op    = OP_DEFINE;
                            n_dup   = 1'b0;
                            n_state = S_COMMIT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    REQ_FIND: n_state = S_SCAN;
                    REQ_START: begin
                        n_op    = OP_START;
                        n_dup   = 1'b0;
                        n_state = S_COMMIT;
                    end
                    default: begin
                        n_op    = OP_FINISH;
                        n_dup   = 1'b0;
                        n_state = S_COMMIT;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_op    = (i_stat.req == REQ_DEFINE) ? OP_DEFINE : OP_HIT;
                    n_dup   = (i_stat.req == REQ_DEFINE);
                    n_state = S_COMMIT;
                end else if (!i_stat.more) begin
                    n_op    = (i_stat.req == REQ_DEFINE) ? OP_DEFINE : OP_MISS;
                    n_dup   = 1'b0;
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### design/sst_dp.sv
// Datapath of the scoped symbol table: entry memory, scan pointer,
// level bases, configuration and result register. Depends on sst_pkg.
`default_nettype none

module sst_dp import sst_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int LEVELS  = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [IN_TDATA_W-1:0]  i_in_data,
    input  wire logic [IN_TUSER_W-1:0]  i_in_user,
    input  wire t_cmd                   i_cmd,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0]      o_out_data
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = $clog2(LEVELS);

    logic [NAME_W-1:0] mem_name [ENTRIES];
    logic [KIND_W-1:0] mem_kind [ENTRIES];

    logic [NAME_W-1:0] r_anon;
    logic [KIND_W-1:0] r_ukind;
    t_req              r_req;
    logic [NAME_W-1:0] r_name;
    logic [KIND_W-1:0] r_kind;
    logic [CW-1:0]     r_count, n_count;
    logic [LW-1:0]     r_lvl, n_lvl;
    logic [CW-1:0]     r_base [LEVELS];
    logic [CW-1:0]     r_ptr, r_low;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;
    logic [NAME_W-1:0] r_rd_name;
    logic [KIND_W-1:0] r_rd_kind;
    logic              r_err, n_err;
    logic              r_out_vld;
    logic [IDX_W-1:0]  r_o_idx;
    logic [KIND_W-1:0] r_o_kind;
    logic              r_o_dup, r_o_undef, r_o_nest, r_o_full, r_o_any;
    logic [LVL_W-1:0]  r_o_lvl;

    logic              full;
    logic [AW-1:0]     rd_addr;
    logic              push_en, base_we;
    logic [KIND_W-1:0] push_kind, res_kind;
    logic [AW-1:0]     slot;
    logic              f_dup, f_undef, f_nest, f_full;

    assign full    = (r_count == CW'(ENTRIES));
    assign rd_addr = AW'(r_ptr - CW'(1));

    assign o_stat.req      = r_req;
    assign o_stat.anon     = (r_name == r_anon);
    assign o_stat.hit      = r_rd_vld && (r_rd_name == r_name);
    assign o_stat.more     = (r_ptr > r_low);
    assign o_stat.out_free = !r_out_vld || i_out_ready;

    always_comb begin
        push_en   = 1'b0;
        push_kind = r_kind;
        res_kind  = '0;
        slot      = '0;
        base_we   = 1'b0;
        f_dup     = 1'b0;
        f_undef   = 1'b0;
        f_nest    = 1'b0;
        f_full    = 1'b0;
        n_count   = r_count;
        n_lvl     = r_lvl;
        if (i_cmd.commit) begin
            case (i_cmd.op)
                OP_DEFINE: begin
                    f_dup = i_cmd.dup;
                    if (full) begin
                        f_full = 1'b1;
                    end else begin
                        push_en  = 1'b1;
                        slot     = r_count[AW-1:0];
                        res_kind = r_kind;
                        n_count  = r_count + CW'(1);
                    end
                end
                OP_HIT: begin
                    slot     = r_rd_addr;
                    res_kind = r_rd_kind;
                end
                OP_MISS: begin
                    f_undef = 1'b1;
                    if (full) begin
                        f_full = 1'b1;
                    end else begin
                        push_en   = 1'b1;
                        push_kind = r_ukind;
                        slot      = r_count[AW-1:0];
                        res_kind  = r_ukind;
                        n_count   = r_count + CW'(1);
                    end
                end
                OP_START: begin
                    if (r_lvl == LW'(LEVELS - 1)) begin
                        f_nest = 1'b1;
                    end else begin
                        n_lvl   = r_lvl + LW'(1);
                        base_we = 1'b1;
                    end
                end
                OP_FINISH: begin
                    if (r_lvl == '0) begin
                        f_nest = 1'b1;
                    end else begin
                        n_count = r_base[r_lvl];
                        n_lvl   = r_lvl - LW'(1);
                    end
                end
                default: ;
            endcase
        end
        n_err = r_err | f_dup | f_undef | f_nest | f_full;
    end

    // entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            mem_name[slot] <= r_name;
            mem_kind[slot] <= push_kind;
        end
        if (i_cmd.step) begin
            r_rd_name <= mem_name[rd_addr];
            r_rd_kind <= mem_kind[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anon    <= '0;
            r_ukind   <= '0;
            r_count   <= '0;
            r_lvl     <= '0;
            r_err     <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            for (int i = 0; i < LEVELS; i++) begin
                r_base[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ANON_NAME:  r_anon  <= i_cfg_data[NAME_W-1:0];
                    CFG_UNDEF_KIND: r_ukind <= i_cfg_data[KIND_W-1:0];
                    default: ;
                endcase
            end
            r_count <= n_count;
            r_lvl   <= n_lvl;
            r_err   <= n_err;
            if (base_we) begin
                r_base[n_lvl] <= r_count;
            end
            if (i_cmd.load) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.step) begin
                r_rd_vld <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= t_req'(i_in_user);
            r_name <= i_in_data[NAME_W-1:0];
            r_kind <= i_in_data[NAME_W +: KIND_W];
            r_ptr  <= r_count;
            r_low  <= (t_req'(i_in_user) == REQ_DEFINE) ? r_base[r_lvl] : '0;
        end else if (i_cmd.step) begin
            r_ptr     <= r_ptr - CW'(1);
            r_rd_addr <= rd_addr;
        end
        if (i_cmd.commit) begin
            r_o_idx   <= IDX_W'(slot);
            r_o_kind  <= res_kind;
            r_o_dup   <= f_dup;
            r_o_undef <= f_undef;
            r_o_nest  <= f_nest;
            r_o_full  <= f_full;
            r_o_lvl   <= LVL_W'(n_lvl);
            r_o_any   <= n_err;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = {3'b000, r_o_any, r_o_lvl, r_o_full, r_o_nest, r_o_undef, r_o_dup,
                          r_o_kind, r_o_idx};

endmodule

`default_nettype wire

### design/scoped_symbol_table_core.sv
// Scoped symbol table: top level joining sst_ctrl and sst_dp.
// Depends on sst_pkg, sst_ctrl and sst_dp.
//
// Nested-scope symbol table on stream ports. Each request beat gives one
// result beat. Start and finish block skip the scan. Define and find compare
// one stored entry per cycle through the entry memory's single read port,
// newest first. A define scans only the current level, and a define of the
// anonymous name skips the scan. One request is in flight at a time; the
// next is accepted once the result is placed in the output register, and a
// result still waiting in that register holds back the next one.
`default_nettype none

module scoped_symbol_table_core import sst_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int LEVELS  = 10
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // name[11:0], kind[15:12]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // entry_index[7:0], entry_kind[11:8], duplicate_error[12], undefined_error[13],
    // nesting_error[14], full_error[15], current_level[19:16], any_error[20], zero[23:21]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    t_cmd  cmd;
    t_stat stat;

    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sst_dp #(
        .ENTRIES (ENTRIES),
        .LEVELS  (LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### sim/scoped_symbol_table_checker.sv
// Scoreboard for the scoped symbol table: watches the config port and both stream channels,
// keeps its own copy of the scope stack and checks every result beat against it.
// Depends on sst_pkg.

module scoped_symbol_table_checker import sst_pkg::*; #(
    parameter int ENTRIES = 256,
    parameter int LEVELS  = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [IN_TDATA_W-1:0]  i_req_data,
    input  logic [IN_TUSER_W-1:0]  i_req_user,
    input  logic                   i_rsp_valid,
    input  logic                   i_rsp_ready,
    input  logic [OUT_TDATA_W-1:0] i_rsp_data,
    output int                     o_fail_count,
    output int                     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // same layout as the result tdata, lowest field last
    typedef struct packed {
        logic [2:0]        pad;
        logic              any_err;
        logic [LVL_W-1:0]  level;
        logic              full_err;
        logic              nest_err;
        logic              undef_err;
        logic              dup_err;
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
    } t_outcome;

    logic [NAME_W-1:0] stored_names [ENTRIES];
    logic [KIND_W-1:0] stored_kinds [ENTRIES];
    int                depth_used;
    int                nest_level;
    int                level_floor [LEVELS];
    logic              sticky;
    logic [NAME_W-1:0] anon_code;
    logic [KIND_W-1:0] fill_kind;
    t_outcome          awaited [$];
    int                fails = 0;

    function automatic int newest_match(logic [NAME_W-1:0] nm, int lowest);
        for (int i = depth_used - 1; i >= lowest; i--) begin
            if (stored_names[i] == nm)
                return i;
        end
        return -1;
    endfunction

    function automatic int push_symbol(logic [NAME_W-1:0] nm, logic [KIND_W-1:0] kd);
        if (depth_used >= ENTRIES)
            return -1;
        stored_names[depth_used] = nm;
        stored_kinds[depth_used] = kd;
        depth_used++;
        return depth_used - 1;
    endfunction

    function automatic t_outcome resolve_request(t_req req, logic [NAME_W-1:0] nm,
                                                 logic [KIND_W-1:0] kd);
        t_outcome res;
        int       cur;
        int       hit;
        int       slot;
        res = '0;
        cur = (nest_level < LEVELS) ? nest_level : LEVELS - 1;
        case (req)
            REQ_DEFINE: begin
                if (nm != anon_code && newest_match(nm, level_floor[cur]) >= 0)
                    res.dup_err = 1'b1;
                slot = push_symbol(nm, kd);
                if (slot >= 0) begin
                    res.index = IDX_W'(slot);
                    res.kind  = kd;
                end else begin
                    res.full_err = 1'b1;
                end
            end
            REQ_FIND: begin
                hit = newest_match(nm, 0);
                if (hit >= 0) begin
                    res.index = IDX_W'(hit);
                    res.kind  = stored_kinds[hit];
                end else begin
                    res.undef_err = 1'b1;
                    slot = push_symbol(nm, fill_kind);
                    if (slot >= 0) begin
                        res.index = IDX_W'(slot);
                        res.kind  = fill_kind;
                    end else begin
                        res.full_err = 1'b1;
                    end
                end
            end
            REQ_START: begin
                if (cur + 1 >= LEVELS) begin
                    res.nest_err = 1'b1;
                end else begin
                    cur++;
                    nest_level = cur;
                    level_floor[cur] = depth_used;
                end
            end
            default: begin
                if (cur == 0) begin
                    res.nest_err = 1'b1;
                end else begin
                    depth_used = level_floor[cur];
                    cur--;
                    nest_level = cur;
                end
            end
        endcase
        if (res.dup_err || res.undef_err || res.nest_err || res.full_err)
            sticky = 1'b1;
        res.level   = LVL_W'(nest_level);
        res.any_err = sticky;
        return res;
    endfunction

    task automatic check_field(string field, int want, int seen);
        if (want != seen) begin
            $error("%s: expected %0d, got %0d", field, want, seen);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome seen;
        if (!i_rst_n) begin
            depth_used = 0;
            nest_level = 0;
            foreach (level_floor[k])
                level_floor[k] = 0;
            sticky    = 1'b0;
            anon_code = '0;
            fill_kind = '0;
            awaited.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ANON_NAME:  anon_code = i_cfg_data[NAME_W-1:0];
                    CFG_UNDEF_KIND: fill_kind = i_cfg_data[KIND_W-1:0];
                    default: ;
                endcase
            end
            if (i_rsp_valid && i_rsp_ready) begin
                seen = i_rsp_data;
                if (awaited.size() == 0) begin
                    $error("result beat with no request outstanding: %h", i_rsp_data);
                    fails++;
                end else begin
                    want = awaited.pop_front();
                    check_field("entry_index", want.index, seen.index);
                    check_field("entry_kind", want.kind, seen.kind);
                    check_field("duplicate_error", want.dup_err, seen.dup_err);
                    check_field("undefined_error", want.undef_err, seen.undef_err);
                    check_field("nesting_error", want.nest_err, seen.nest_err);
                    check_field("full_error", want.full_err, seen.full_err);
                    check_field("current_level", want.level, seen.level);
                    check_field("any_error", want.any_err, seen.any_err);
                    check_field("tdata padding", want.pad, seen.pad);
                end
            end
            if (i_req_valid && i_req_ready)
                awaited.push_back(resolve_request(t_req'(i_req_user), i_req_data[NAME_W-1:0],
                                                  i_req_data[NAME_W +: KIND_W]));
        end
        o_pending    = awaited.size();
        o_fail_count = fails;
    end

endmodule

### sim/scoped_symbol_table_core_tb.sv
// Top of the scoped symbol table testbench: clock, reset, request and config stimulus,
// result back-pressure and the final verdict.
// Depends on sst_pkg, scoped_symbol_table_core and scoped_symbol_table_checker.

module scoped_symbol_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int ENTRIES      = 256;
    localparam int LEVELS       = 10;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 4_000_000;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = CFG_ANON_NAME;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tready = 1'b0;
    wire                    s_axis_tready;
    wire                    m_axis_tvalid;
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                scope_depth = 0;
    int                settings_used = 1;
    int                req_tally [4] = '{0, 0, 0, 0};
    bit                calm = 1'b0;
    logic [NAME_W-1:0] anon_code = '0;

    scoped_symbol_table_core #(
        .ENTRIES(ENTRIES),
        .LEVELS (LEVELS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    scoped_symbol_table_checker #(
        .ENTRIES(ENTRIES),
        .LEVELS (LEVELS)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_rsp_data  (m_axis_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped by the cycle limit after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result back-pressure: ready bursts broken by stalls
    initial begin : sink_pacing
        int run_len;
        int hold;
        forever begin
            run_len = $urandom_range(1, 24);
            repeat (run_len) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            hold = calm ? 0 : idle_cycles();
            repeat (hold) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // called at a falling edge; returns at a falling edge after the beat is taken
    task automatic issue(input t_req req, input logic [NAME_W-1:0] nm,
                         input logic [KIND_W-1:0] kd);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {kd, nm};
        do @(posedge i_clk); while (!s_axis_tready);
        req_tally[req]++;
        case (req)
            REQ_START:  if (scope_depth < LEVELS - 1) scope_depth++;
            REQ_FINISH: if (scope_depth > 0) scope_depth--;
            default: ;
        endcase
        @(negedge i_clk);
        gap = calm ? 0 : idle_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_registers(input logic [CFG_DATA_W-1:0] anon,
                                 input logic [CFG_DATA_W-1:0] undef_word);
        settle();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_ANON_NAME;
        i_cfg_data  <= anon;
        @(negedge i_clk);
        i_cfg_index <= CFG_UNDEF_KIND;
        i_cfg_data  <= undef_word;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        anon_code = anon[NAME_W-1:0];
        settings_used++;
    endtask

    // random walk through the levels: climb to the limit, then unwind to level zero
    task automatic random_phase(input int count);
        logic [NAME_W-1:0] pool [12];
        bit                climbing;
        int                pick;
        logic [NAME_W-1:0] nm;
        t_req              req;
        climbing = scope_depth < LEVELS / 2;
        foreach (pool[k])
            pool[k] = NAME_W'($urandom());
        for (int n = 0; n < count; n++) begin
            calm = (n % 200) < 30;
            if (scope_depth == LEVELS - 1 && $urandom_range(0, 3) == 0)
                climbing = 1'b0;
            else if (scope_depth == 0 && $urandom_range(0, 3) == 0)
                climbing = 1'b1;
            pick = $urandom_range(0, 99);
            if (scope_depth == 0 && climbing) begin
                if (pick < 60)      req = REQ_START;
                else if (pick < 75) req = REQ_DEFINE;
                else if (pick < 90) req = REQ_FIND;
                else                req = REQ_FINISH;
            end else if (climbing) begin
                if (pick < 25)      req = REQ_START;
                else if (pick < 33) req = REQ_FINISH;
                else if (pick < 68) req = REQ_DEFINE;
                else                req = REQ_FIND;
            end else begin
                if (pick < 8)       req = REQ_START;
                else if (pick < 33) req = REQ_FINISH;
                else if (pick < 66) req = REQ_DEFINE;
                else                req = REQ_FIND;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7)      nm = pool[$urandom_range(0, 11)];
            else if (pick < 8) nm = anon_code;
            else               nm = NAME_W'($urandom());
            issue(req, nm, KIND_W'($urandom()));
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, anonymous name 0 and undefined kind 0
        issue(REQ_FINISH, 12'h000, 4'h0);
        issue(REQ_FIND,   12'h123, 4'h0);
        issue(REQ_DEFINE, 12'h000, 4'hF);
        issue(REQ_DEFINE, 12'h000, 4'h1);
        issue(REQ_DEFINE, 12'hFFF, 4'hF);
        issue(REQ_DEFINE, 12'hFFF, 4'h0);
        issue(REQ_FIND,   12'hFFF, 4'h5);
        issue(REQ_FIND,   12'h123, 4'hA);
        issue(REQ_START,  12'h000, 4'h0);
        issue(REQ_DEFINE, 12'hFFF, 4'hA);
        issue(REQ_FIND,   12'hABC, 4'h3);
        issue(REQ_FINISH, 12'hFFF, 4'hF);
        issue(REQ_FIND,   12'hABC, 4'hC);
        repeat (LEVELS) issue(REQ_START, 12'h555, 4'h6);

        set_registers(12'hFFF, 12'h00F);
        random_phase(RANDOM_ITEMS);

        // fill the store inside a fresh level, hit the full case, then pop it
        set_registers(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        while (scope_depth != 0)
            issue(REQ_FINISH, NAME_W'($urandom()), KIND_W'($urandom()));
        issue(REQ_START, NAME_W'($urandom()), KIND_W'($urandom()));
        repeat (ENTRIES + 2) issue(REQ_DEFINE, anon_code, KIND_W'($urandom()));
        issue(REQ_DEFINE, NAME_W'($urandom()), KIND_W'($urandom()));
        repeat (3) issue(REQ_FIND, NAME_W'($urandom()), KIND_W'($urandom()));
        issue(REQ_FINISH, NAME_W'($urandom()), KIND_W'($urandom()));

        set_registers(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
        random_phase(RANDOM_ITEMS);
        set_registers(12'h000, 12'h000);
        random_phase(RANDOM_ITEMS);

        settle();
        repeat (ENTRIES + 8) @(negedge i_clk);

        $display("Sent %0d defines, %0d finds, %0d block starts and %0d block finishes",
                 req_tally[REQ_DEFINE], req_tally[REQ_FIND], req_tally[REQ_START],
                 req_tally[REQ_FINISH]);
        $display("over %0d register settings, with a filled store and the level limit reached",
                 settings_used);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
design/sst_pkg.sv
design/sst_ctrl.sv
design/sst_dp.sv
design/scoped_symbol_table_core.sv
sim/scoped_symbol_table_checker.sv
sim/scoped_symbol_table_core_tb.sv
